>>> design/triangle_filter_rasterizer_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef TRIANGLE_FILTER_RASTERIZER_ASSERT_SVH
`define TRIANGLE_FILTER_RASTERIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/tfr_pkg.sv
// Package with the word types, kind codes and command types of the rasterizer.
package tfr_pkg;
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SCORE = 2'd3;
  localparam logic [23:0] WHITE_PIXEL = 24'hFFFFFF;
  localparam int SUM_W = 35;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  v0_row;
    logic [8:0]  v0_col;
    logic [7:0]  v1_row;
    logic [8:0]  v1_col;
    logic [7:0]  v2_row;
    logic [8:0]  v2_col;
    logic [15:0] gain_red;
    logic [15:0] gain_green;
    logic [15:0] gain_blue;
    logic [23:0] target_pixel;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_blue;
    logic [SUM_W-1:0] error_sum;
    logic             sum_valid;
    logic             done_res;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture input word, sort vertices
    logic clr_start;   // reset clear address
    logic clr_step;    // write white, advance address
    logic row_start;   // begin at top row
    logic div_start;   // start both edge divisions for current row
    logic span_init;   // take span bounds
    logic px_read;     // capture pixel read at current column
    logic px_write;    // write filtered pixel, advance column
    logic row_next;    // advance row
    logic pt_read;     // never raised by the controller; unused
    logic finish;      // form result word
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic kind_clear;
    logic kind_draw;
    logic flat;
    logic clr_last;
    logic div_busy;
    logic span_last;
    logic row_last;
  } sts_t;
endpackage

>>> design/tfr_if.sv
// Valid/ready channel interfaces for the input and result words.
interface tfr_in_if;
  logic               valid;
  logic               ready;
  tfr_pkg::in_word_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tfr_out_if;
  logic               valid;
  logic               ready;
  tfr_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/tfr_ram.sv
// Generic single-port RAM with registered read.
module tfr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

>>> design/tfr_div.sv
// Restoring divider, one quotient bit per cycle.
module tfr_div #(
  parameter int NW = 24,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW+1:0] trial;

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    d_nxt   = d_r;
    cnt_nxt = cnt_r;
    trial   = '0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      d_nxt   = den;
      cnt_nxt = CW'(NW);
    end else if (busy) begin
      trial = {rem_r, q_r[NW-1]} - {2'b00, d_r};
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end
endmodule

>>> design/tfr_datapath.sv
// Datapath: vertex sort, edge interpolation, canvas access, filter and score.
module tfr_datapath #(
  parameter int ROWS = 256,
  parameter int COLS = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfr_pkg::in_word_t   in_data,
  input  tfr_pkg::cmd_t       cmd,
  output tfr_pkg::sts_t       sts,
  output tfr_pkg::out_word_t  res
);
  localparam int RW = $clog2(ROWS);
  localparam int CLW = $clog2(COLS);
  localparam int AW = $clog2(ROWS * COLS);
  localparam int NW = CLW + RW + 3;
  localparam int DW = RW + 1;
  localparam logic [RW-1:0] RMAX = RW'(ROWS - 1);
  localparam logic [CLW-1:0] CMAX = CLW'(COLS - 1);
  localparam logic [tfr_pkg::SUM_W-1:0] SUM_MAX = '1;
  localparam logic [23:0] WHITE = tfr_pkg::WHITE_PIXEL;

  tfr_pkg::in_word_t w_r;
  logic [RW-1:0]  vr0_r, vr1_r, vr2_r, row_r;
  logic [CLW-1:0] vc0_r, vc1_r, vc2_r, col_r, hi_r;
  logic [AW-1:0]  clr_r;
  logic [tfr_pkg::SUM_W-1:0] acc_r;
  logic [23:0] px_r;
  tfr_pkg::out_word_t res_r;

  // Saturate a coordinate to the grid.
  function automatic logic [RW-1:0] sat_r(input logic [7:0] v);
    sat_r = ({1'b0, v} > {1'b0, 8'(ROWS - 1)} && ROWS <= 256) ? RMAX : RW'(v);
  endfunction
  function automatic logic [CLW-1:0] sat_c(input logic [8:0] v);
    sat_c = (COLS <= 512 && v > 9'(COLS - 1)) ? CMAX : CLW'(v);
  endfunction

  // Sorting network on saturated vertices.
  logic [RW-1:0]  a_r [3];
  logic [CLW-1:0] a_c [3];
  logic [RW-1:0]  tr;
  logic [CLW-1:0] tc;
  always_comb begin
    tr = '0;
    tc = '0;
    a_r[0] = sat_r(in_data.v0_row); a_c[0] = sat_c(in_data.v0_col);
    a_r[1] = sat_r(in_data.v1_row); a_c[1] = sat_c(in_data.v1_col);
    a_r[2] = sat_r(in_data.v2_row); a_c[2] = sat_c(in_data.v2_col);
    if (a_r[0] > a_r[1]) begin
      tr = a_r[0]; a_r[0] = a_r[1]; a_r[1] = tr;
      tc = a_c[0]; a_c[0] = a_c[1]; a_c[1] = tc;
    end
    if (a_r[1] > a_r[2]) begin
      tr = a_r[1]; a_r[1] = a_r[2]; a_r[2] = tr;
      tc = a_c[1]; a_c[1] = a_c[2]; a_c[2] = tc;
    end
    if (a_r[0] > a_r[1]) begin
      tr = a_r[0]; a_r[0] = a_r[1]; a_r[1] = tr;
      tc = a_c[0]; a_c[0] = a_c[1]; a_c[1] = tc;
    end
  end

  // Edge selection for the current row: edge A is the short edge, B the long one.
  logic [RW-1:0]  ea_ra, ea_rb;
  logic [CLW-1:0] ea_ca, ea_cb;
  always_comb begin
    if (vr0_r == vr1_r || row_r > vr1_r) begin
      ea_ra = vr1_r; ea_ca = vc1_r; ea_rb = vr2_r; ea_cb = vc2_r;
    end else begin
      ea_ra = vr0_r; ea_ca = vc0_r; ea_rb = vr1_r; ea_cb = vc1_r;
    end
  end

  // Numerator 2*(ca*d + (cb-ca)*t) + d, with d, t at most ROWS-1; never negative
  // because the result is a convex blend of ca and cb.
  function automatic logic [NW-1:0] edge_num(input logic [RW-1:0] ra, input logic [CLW-1:0] ca,
                                            input logic [RW-1:0] rb, input logic [CLW-1:0] cb,
                                            input logic [RW-1:0] r);
    logic [RW:0] d, t;
    logic [NW+1:0] p;
    d = {1'b0, rb} - {1'b0, ra};
    t = {1'b0, r} - {1'b0, ra};
    p = (NW+2)'(ca) * (NW+2)'(d - t) + (NW+2)'(cb) * (NW+2)'(t);
    edge_num = NW'({p, 1'b0} + (NW+3)'(d));
  endfunction

  logic [NW-1:0] na, nb;
  logic [DW-1:0] da, db;
  logic busy_a, busy_b;
  logic [NW-1:0] qa, qb;
  assign na = edge_num(ea_ra, ea_ca, ea_rb, ea_cb, row_r);
  assign nb = edge_num(vr0_r, vc0_r, vr2_r, vc2_r, row_r);
  assign da = DW'({1'b0, ea_rb} - {1'b0, ea_ra}) << 1;
  assign db = DW'({1'b0, vr2_r} - {1'b0, vr0_r}) << 1;

  tfr_div #(.NW(NW), .DW(DW)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(na), .den(da),
    .busy(busy_a), .quo(qa));
  tfr_div #(.NW(NW), .DW(DW)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(nb), .den(db),
    .busy(busy_b), .quo(qb));

  logic [CLW-1:0] ca_q, cb_q;
  assign ca_q = CLW'(qa);
  assign cb_q = CLW'(qb);

  // Canvas memory.
  logic          we;
  logic [AW-1:0] addr;
  logic [23:0]   wdata, rdata;
  logic [AW-1:0] px_addr;
  assign px_addr = AW'(row_r) * AW'(COLS) + AW'(col_r);

  function automatic logic [7:0] scale(input logic [7:0] v, input logic [15:0] g);
    logic [23:0] p;
    p = 24'(v) * 24'(g);
    scale = (p[23:15] > 9'd255) ? 8'hFF : p[22:15];
  endfunction

  always_comb begin
    we    = 1'b0;
    addr  = px_addr;
    wdata = WHITE;
    if (cmd.clr_step) begin
      we = 1'b1; addr = clr_r;
    end else if (cmd.px_write) begin
      we = 1'b1;
      wdata = {scale(px_r[23:16], w_r.gain_red), scale(px_r[15:8], w_r.gain_green),
               scale(px_r[7:0], w_r.gain_blue)};
    end
  end

  tfr_ram #(.WIDTH(24), .DEPTH(ROWS * COLS)) u_canvas (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // Score terms.
  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a >= b) ? a - b : b - a;
  endfunction

  logic [7:0]  dr, dg, dbl;
  logic [17:0] sq;
  logic [tfr_pkg::SUM_W:0] acc_sum;
  always_comb begin
    dr  = absdiff(w_r.target_pixel[23:16], rdata[23:16]);
    dg  = absdiff(w_r.target_pixel[15:8], rdata[15:8]);
    dbl = absdiff(w_r.target_pixel[7:0], rdata[7:0]);
    sq = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(dbl) * 18'(dbl);
    acc_sum = {1'b0, acc_r} + (tfr_pkg::SUM_W+1)'(sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.finish && w_r.kind == tfr_pkg::KIND_SCORE) begin
      if (w_r.last) acc_r <= '0;
      else acc_r <= acc_sum[tfr_pkg::SUM_W] ? SUM_MAX : acc_sum[tfr_pkg::SUM_W-1:0];
    end
    if (cmd.load) begin
      w_r <= in_data;
      vr0_r <= a_r[0]; vr1_r <= a_r[1]; vr2_r <= a_r[2];
      vc0_r <= a_c[0]; vc1_r <= a_c[1]; vc2_r <= a_c[2];
      row_r <= sat_r(in_data.v0_row);
      col_r <= sat_c(in_data.v0_col);
    end
    if (!rst_n || cmd.clr_start) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
    if (cmd.row_start) row_r <= vr0_r;
    else if (cmd.row_next) row_r <= row_r + 1'b1;
    if (cmd.span_init) begin
      col_r <= (ca_q < cb_q) ? ca_q : cb_q;
      hi_r  <= (ca_q < cb_q) ? cb_q : ca_q;
    end else if (cmd.px_write) begin
      col_r <= col_r + 1'b1;
    end
    if (cmd.px_read) px_r <= rdata;
    if (cmd.finish) begin
      res_r.pixel_red   <= (w_r.kind == tfr_pkg::KIND_READ) ? rdata[23:16] : 8'd0;
      res_r.pixel_green <= (w_r.kind == tfr_pkg::KIND_READ) ? rdata[15:8] : 8'd0;
      res_r.pixel_blue  <= (w_r.kind == tfr_pkg::KIND_READ) ? rdata[7:0] : 8'd0;
      res_r.sum_valid   <= (w_r.kind == tfr_pkg::KIND_SCORE) && w_r.last;
      res_r.error_sum   <= ((w_r.kind == tfr_pkg::KIND_SCORE) && w_r.last) ?
                           (acc_sum[tfr_pkg::SUM_W] ? SUM_MAX
                                                    : acc_sum[tfr_pkg::SUM_W-1:0]) : '0;
      res_r.done_res    <= 1'b1;
    end
  end

  assign res = res_r;
  assign sts.kind_clear = (w_r.kind == tfr_pkg::KIND_CLEAR);
  assign sts.kind_draw  = (w_r.kind == tfr_pkg::KIND_DRAW);
  assign sts.flat       = (vr0_r == vr2_r);
  assign sts.clr_last   = (clr_r == AW'(ROWS * COLS - 1));
  assign sts.div_busy   = busy_a | busy_b;
  assign sts.span_last  = (col_r == hi_r);
  assign sts.row_last   = (row_r == vr2_r);
endmodule

>>> design/tfr_ctrl.sv
// Controller state machine sequencing clear, draw, read and score.
module tfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tfr_pkg::sts_t sts,
  output tfr_pkg::cmd_t cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_ROW   = 4'd3;
  localparam logic [3:0] S_DIVW  = 4'd4;
  localparam logic [3:0] S_SPAN  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_PT    = 4'd9;
  localparam logic [3:0] S_PTW   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       rst_done_r;

  // A new word is taken once the previous result has been delivered or is leaving.
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.kind_clear) begin
          cmd.clr_start = 1'b1; state_nxt = S_CLR;
        end else if (sts.kind_draw) begin
          cmd.row_start = 1'b1;
          state_nxt = sts.flat ? S_FIN : S_ROW;
        end else begin
          state_nxt = S_PT;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_FIN;
      end
      S_ROW: begin
        cmd.div_start = 1'b1; state_nxt = S_DIVW;
      end
      S_DIVW: if (!sts.div_busy) begin
        cmd.span_init = 1'b1; state_nxt = S_RD;
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        cmd.px_read = 1'b1; state_nxt = S_WR;
      end
      S_WR: begin
        cmd.px_write = 1'b1;
        if (!sts.span_last) state_nxt = S_RD;
        else if (sts.row_last) state_nxt = S_FIN;
        else begin
          cmd.row_next = 1'b1; state_nxt = S_ROW;
        end
      end
      S_SPAN: state_nxt = S_RD;
      S_PT: state_nxt = S_PTW;
      S_PTW: state_nxt = S_FIN;
      S_FIN: if (!ov_r) begin
        cmd.finish = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
    end else begin
      // The reset pass whitens the canvas and emits no word.
      if (state_r == S_CLR && sts.clr_last && ov_r == 1'b0 && rst_done_r == 1'b0) begin
        state_r <= S_IDLE;
      end else begin
        state_r <= state_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rst_done_r <= 1'b0;
    else if (state_r == S_CLR && sts.clr_last) rst_done_r <= 1'b1;
  end
endmodule

>>> design/triangle_filter_rasterizer.sv
// Top level of the triangle filter rasterizer.
//  channel | dir | word
//  in_     | in  | kind, three vertices, three gains, target pixel, last
//  out_    | out | pixel channels, error sum, sum valid, done
// Clear whitens every canvas pixel in turn. Per draw row both edge divisions run
// side by side, then each span pixel is read, waited on and written back filtered
// through the single canvas port. After reset a clearing pass whitens the canvas; no
// word is taken meanwhile. A stalled result holds the controller before the next word.
module triangle_filter_rasterizer #(
  parameter int ROWS = 256,
  parameter int COLS = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  tfr_in_if.sink        in_ch,
  tfr_out_if.source     out_ch
);
  tfr_pkg::cmd_t cmd;
  tfr_pkg::sts_t sts;

  tfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));

  tfr_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .res(out_ch.data));
endmodule

>>> design/tfr_checker.sv
// Port-level checker for the rasterizer and its bind.
`include "triangle_filter_rasterizer_assert.svh"
module tfr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_done,
  input logic out_sum_valid
);
  `TFR_ASSERT_IMP(a_done, clk, rst_n, out_valid, out_done)
  `TFR_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `TFR_ASSERT_NXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `TFR_ASSERT_NXT(a_sum_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sum_valid))
endmodule

bind triangle_filter_rasterizer tfr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_done(out_ch.data.done_res), .out_sum_valid(out_ch.data.sum_valid));

>>> tb/sv/tb_triangle_filter_rasterizer.sv
// Self-checking testbench for the triangle filter rasterizer: directed table, then random words.
module tb_triangle_filter_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 256;
  localparam int COLS = 512;
  localparam logic [tfr_pkg::SUM_W-1:0] SUM_MAX = {tfr_pkg::SUM_W{1'b1}};
  localparam int RAND_WORDS = 120;
  localparam int STALL_LIMIT = 500000;
  localparam int END_WAIT = 20;

  typedef struct {
    tfr_pkg::in_word_t  w;
    bit                 has_exp;
    tfr_pkg::out_word_t exp_word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tfr_in_if  in_ch();
  tfr_out_if out_ch();

  triangle_filter_rasterizer #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  logic [23:0]               canvas_px [0:ROWS*COLS-1];
  logic [tfr_pkg::SUM_W-1:0] err_acc;
  tfr_pkg::out_word_t        pending_q[$];
  dir_row_t                  dir_q[$];
  bit                        failed = 1'b0;
  bit                        no_idle = 1'b0;
  int                        idle_cycles = 0;
  int                        last_row = 0;
  int                        last_col = 0;

  function automatic tfr_pkg::in_word_t mk_word(logic [1:0] kind, int r0, int c0, int r1,
                                                int c1, int r2, int c2, int gr, int gg,
                                                int gb, logic [23:0] tp, bit lst);
    tfr_pkg::in_word_t w;
    w.kind = kind;
    w.v0_row = 8'(r0); w.v0_col = 9'(c0);
    w.v1_row = 8'(r1); w.v1_col = 9'(c1);
    w.v2_row = 8'(r2); w.v2_col = 9'(c2);
    w.gain_red = 16'(gr); w.gain_green = 16'(gg); w.gain_blue = 16'(gb);
    w.target_pixel = tp;
    w.last = lst;
    return w;
  endfunction

  function automatic tfr_pkg::out_word_t mk_result(int pr, int pg, int pb,
                                                   logic [tfr_pkg::SUM_W-1:0] s, bit sv);
    tfr_pkg::out_word_t o;
    o.pixel_red = 8'(pr); o.pixel_green = 8'(pg); o.pixel_blue = 8'(pb);
    o.error_sum = s;
    o.sum_valid = sv;
    o.done_res = 1'b1;
    return o;
  endfunction

  function automatic void add_row(tfr_pkg::in_word_t w, bit has_exp, tfr_pkg::out_word_t e);
    dir_row_t d;
    d.w = w; d.has_exp = has_exp; d.exp_word = e;
    dir_q = {dir_q, d};
  endfunction

  function automatic void whiten_canvas();
    for (int i = 0; i < ROWS*COLS; i++) canvas_px[i] = tfr_pkg::WHITE_PIXEL;
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] v, logic [15:0] g);
    logic [23:0] p;
    p = (24'(v) * 24'(g)) >> 15;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  // Rounded-half-up column of an edge, using exact integer arithmetic.
  function automatic longint edge_column(longint ra, longint ca, longint rb, longint cb,
                                         longint r);
    longint d, num, top;
    d = rb - ra;
    num = ca * d + (cb - ca) * (r - ra);
    top = 2 * num + d;
    if (top < 0) top = 0;
    return top / (2 * d);
  endfunction

  function automatic void filter_span(longint r, longint c1, longint c2,
                                      tfr_pkg::in_word_t w);
    longint lo, hi;
    int idx;
    logic [23:0] px;
    lo = (c1 < c2) ? c1 : c2;
    hi = (c1 < c2) ? c2 : c1;
    if (r < 0 || r >= ROWS) return;
    if (lo < 0) lo = 0;
    if (hi > COLS - 1) hi = COLS - 1;
    for (longint c = lo; c <= hi; c++) begin
      idx = int'(r) * COLS + int'(c);
      px = canvas_px[idx];
      canvas_px[idx] = {scale_chan(px[23:16], w.gain_red), scale_chan(px[15:8], w.gain_green),
                        scale_chan(px[7:0], w.gain_blue)};
    end
  endfunction

  function automatic void fill_triangle(tfr_pkg::in_word_t w);
    longint vr[3], vc[3], t;
    vr[0] = w.v0_row; vc[0] = w.v0_col;
    vr[1] = w.v1_row; vc[1] = w.v1_col;
    vr[2] = w.v2_row; vc[2] = w.v2_col;
    if (vr[0] > vr[1]) begin
      t = vr[0]; vr[0] = vr[1]; vr[1] = t; t = vc[0]; vc[0] = vc[1]; vc[1] = t;
    end
    if (vr[1] > vr[2]) begin
      t = vr[1]; vr[1] = vr[2]; vr[2] = t; t = vc[1]; vc[1] = vc[2]; vc[2] = t;
    end
    if (vr[0] > vr[1]) begin
      t = vr[0]; vr[0] = vr[1]; vr[1] = t; t = vc[0]; vc[0] = vc[1]; vc[1] = t;
    end
    if (vr[0] == vr[2]) return;
    if (vr[0] == vr[1]) begin
      for (longint r = vr[0]; r <= vr[2]; r++)
        filter_span(r, edge_column(vr[0], vc[0], vr[2], vc[2], r),
                    edge_column(vr[1], vc[1], vr[2], vc[2], r), w);
      return;
    end
    for (longint r = vr[0]; r <= vr[1]; r++)
      filter_span(r, edge_column(vr[0], vc[0], vr[1], vc[1], r),
                  edge_column(vr[0], vc[0], vr[2], vc[2], r), w);
    for (longint r = vr[1] + 1; r <= vr[2]; r++)
      filter_span(r, edge_column(vr[1], vc[1], vr[2], vc[2], r),
                  edge_column(vr[0], vc[0], vr[2], vc[2], r), w);
  endfunction

  // Applies one word to the canvas copy and returns the result it must produce.
  function automatic tfr_pkg::out_word_t canvas_op(tfr_pkg::in_word_t w);
    tfr_pkg::out_word_t o;
    logic [23:0] px;
    logic [tfr_pkg::SUM_W:0] acc;
    int dd;
    o = mk_result(0, 0, 0, '0, 1'b0);
    px = canvas_px[int'(w.v0_row) * COLS + int'(w.v0_col)];
    case (w.kind)
      tfr_pkg::KIND_CLEAR: whiten_canvas();
      tfr_pkg::KIND_DRAW: fill_triangle(w);
      tfr_pkg::KIND_READ: begin
        o.pixel_red = px[23:16]; o.pixel_green = px[15:8]; o.pixel_blue = px[7:0];
      end
      default: begin
        acc = {1'b0, err_acc};
        for (int s = 0; s < 24; s += 8) begin
          dd = int'(w.target_pixel[s +: 8]) - int'(px[s +: 8]);
          acc += (tfr_pkg::SUM_W+1)'(dd * dd);
        end
        err_acc = (acc > SUM_MAX) ? SUM_MAX : acc[tfr_pkg::SUM_W-1:0];
        if (w.last) begin
          o.error_sum = err_acc;
          o.sum_valid = 1'b1;
          err_acc = '0;
        end
      end
    endcase
    return o;
  endfunction

  function automatic int clampi(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_gain();
    return ($urandom_range(0, 4) == 0) ? 32768 : $urandom_range(0, 32768);
  endfunction

  function automatic tfr_pkg::in_word_t random_word();
    tfr_pkg::in_word_t w;
    int sel, br, bc;
    w = mk_word(tfr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                24'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)));
    w.v1_row = 8'($urandom_range(0, ROWS - 1)); w.v1_col = 9'($urandom_range(0, COLS - 1));
    w.v2_row = 8'($urandom_range(0, ROWS - 1)); w.v2_col = 9'($urandom_range(0, COLS - 1));
    w.gain_red = 16'(pick_gain()); w.gain_green = 16'(pick_gain());
    w.gain_blue = 16'(pick_gain());
    sel = $urandom_range(0, 99);
    if (sel == 0) begin
      w.kind = tfr_pkg::KIND_CLEAR;
    end else if (sel < 40) begin
      // Small triangles keep the draw time short.
      br = $urandom_range(0, ROWS - 1);
      bc = $urandom_range(0, COLS - 1);
      last_row = br; last_col = bc;
      w.kind = tfr_pkg::KIND_DRAW;
      w.v0_row = 8'(clampi(br + $urandom_range(0, 24) - 12, ROWS - 1));
      w.v0_col = 9'(clampi(bc + $urandom_range(0, 24) - 12, COLS - 1));
      w.v1_row = 8'(clampi(br + $urandom_range(0, 24) - 12, ROWS - 1));
      w.v1_col = 9'(clampi(bc + $urandom_range(0, 24) - 12, COLS - 1));
      w.v2_row = 8'(clampi(br + $urandom_range(0, 24) - 12, ROWS - 1));
      w.v2_col = 9'(clampi(bc + $urandom_range(0, 24) - 12, COLS - 1));
    end else begin
      w.kind = (sel < 72) ? tfr_pkg::KIND_READ : tfr_pkg::KIND_SCORE;
      if ($urandom_range(0, 3) == 0) begin
        w.v0_row = 8'($urandom_range(0, ROWS - 1));
        w.v0_col = 9'($urandom_range(0, COLS - 1));
      end else begin
        w.v0_row = 8'(clampi(last_row + $urandom_range(0, 16) - 8, ROWS - 1));
        w.v0_col = 9'(clampi(last_col + $urandom_range(0, 16) - 8, COLS - 1));
      end
      if (w.kind == tfr_pkg::KIND_SCORE) w.last = ($urandom_range(0, 3) == 0);
    end
    return w;
  endfunction

  task automatic send_word(tfr_pkg::in_word_t w, bit may_idle, bit has_exp,
                           tfr_pkg::out_word_t e);
    tfr_pkg::out_word_t pred;
    if (may_idle && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    pred = canvas_op(w);
    pending_q = {pending_q, (has_exp ? e : pred)};
  endtask

  // Result checker, receiver stalls and watchdog.
  always @(posedge clk) begin
    tfr_pkg::out_word_t e, a;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (pending_q.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1'b1;
        end else begin
          e = pending_q.pop_front();
          if (a.pixel_red !== e.pixel_red) begin
            $error("pixel_red exp %0d got %0d", e.pixel_red, a.pixel_red); failed = 1'b1;
          end
          if (a.pixel_green !== e.pixel_green) begin
            $error("pixel_green exp %0d got %0d", e.pixel_green, a.pixel_green); failed = 1'b1;
          end
          if (a.pixel_blue !== e.pixel_blue) begin
            $error("pixel_blue exp %0d got %0d", e.pixel_blue, a.pixel_blue); failed = 1'b1;
          end
          if (a.error_sum !== e.error_sum) begin
            $error("error_sum exp %0d got %0d", e.error_sum, a.error_sum); failed = 1'b1;
          end
          if (a.sum_valid !== e.sum_valid) begin
            $error("sum_valid exp %0d got %0d", e.sum_valid, a.sum_valid); failed = 1'b1;
          end
          if (a.done_res !== e.done_res) begin
            $error("done_res exp %0d got %0d", e.done_res, a.done_res); failed = 1'b1;
          end
        end
      end
      // A window with the receiver always ready.
      if (no_idle) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 99) >= 33);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    whiten_canvas();
    err_acc = '0;

    add_row(mk_word(tfr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_result(255, 255, 255, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 255, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_result(255, 255, 255, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_SCORE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 1), 1,
            mk_result(0, 0, 0, 0, 1));
    add_row(mk_word(tfr_pkg::KIND_SCORE, 5, 5, 0, 0, 0, 0, 0, 0, 0, 24'h000000, 0), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_SCORE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h000000, 1), 1,
            mk_result(0, 0, 0, 390150, 1));
    // Three vertices on one row leave the canvas untouched.
    add_row(mk_word(tfr_pkg::KIND_DRAW, 20, 50, 20, 100, 20, 150, 0, 0, 0, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 20, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_result(255, 255, 255, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_DRAW, 0, 509, 255, 511, 128, 510, 16384, 16384, 16384,
                    0, 0), 1, mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 128, 510, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_READ, 0, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_DRAW, 30, 10, 30, 40, 60, 25, 0, 32768, 16384, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 30, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_READ, 45, 25, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_DRAW, 70, 100, 90, 80, 90, 120, 32768, 0, 8191, 0, 0), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 90, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    // Last is ignored on a draw.
    add_row(mk_word(tfr_pkg::KIND_DRAW, 200, 0, 210, 5, 205, 0, 1000, 2000, 3000, 0, 1), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 205, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_SCORE, 205, 0, 0, 0, 0, 0, 0, 0, 0, 24'h123456, 1), 0, '0);
    add_row(mk_word(tfr_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
            mk_result(0, 0, 0, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 128, 510, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_result(255, 255, 255, 0, 0));
    add_row(mk_word(tfr_pkg::KIND_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
            mk_result(255, 255, 255, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) send_word(dir_q[i].w, 1'b1, dir_q[i].has_exp, dir_q[i].exp_word);
    for (int i = 0; i < RAND_WORDS; i++) begin
      no_idle = (i >= 50 && i < 80);
      send_word(random_word(), !no_idle, 1'b0, '0);
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/tfr_pkg.sv
design/tfr_if.sv
design/tfr_ram.sv
design/tfr_div.sv
design/tfr_datapath.sv
design/tfr_ctrl.sv
design/triangle_filter_rasterizer.sv
design/tfr_checker.sv
tb/sv/tb_triangle_filter_rasterizer.sv
